// File: rtl/core/bod_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bod_pkg
// Shared types, codes and helpers of the bandwidth-on-demand controller.
// ----------------------------------------------------------------------------
package bod_pkg;

  // divider operand widths: delta*1000 needs 42 bits, the filtered sum 43
  localparam int DIV_W  = 43;
  localparam int DVS_W  = 16;
  localparam int STEP_W = $clog2(DIV_W);

  // configuration register indexes
  localparam logic [2:0] REG_ENABLE       = 3'd0;
  localparam logic [2:0] REG_FILTER_LEN   = 3'd1;
  localparam logic [2:0] REG_RATE_LIMIT   = 3'd2;
  localparam logic [2:0] REG_STAY_UP      = 3'd3;
  localparam logic [2:0] REG_STAY_UP_TIME = 3'd4;

  // link commands
  localparam logic [1:0] LINK_NONE   = 2'd0;
  localparam logic [1:0] LINK_ADD    = 2'd1;
  localparam logic [1:0] LINK_REMOVE = 2'd2;

  localparam logic [9:0] RATE_SCALE = 10'd1000;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DVS_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_W-1:0]     quotient;
  } div_rsp_t;

  function automatic logic [31:0] sat32(input logic [DIV_W-1:0] v);
    logic [31:0] r;
    if (|v[DIV_W-1:32]) begin
      r = 32'hFFFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/bod_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bod_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bod_div (
  input  logic              clk,
  input  logic              rst,
  input  bod_pkg::div_req_t req,
  output bod_pkg::div_rsp_t rsp
);
  import bod_pkg::*;

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [DIV_W-1:0]  work;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;

  logic [DVS_W:0]    rem_sh;
  logic [DVS_W:0]    diff;
  logic              ge;
  logic [DVS_W-1:0]  rem_next;

  assign rem_sh   = {rem, work[DIV_W-1]};
  assign diff     = rem_sh - {1'b0, dvs};
  assign ge       = (rem_sh >= {1'b0, dvs});
  assign rem_next = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  // datapath: quotient bits shift in where the dividend shifts out
  always_ff @(posedge clk) begin
    if (req.start) begin
      work <= req.dividend;
      rem  <= '0;
      dvs  <= req.divisor;
    end else if (busy) begin
      work <= {work[DIV_W-2:0], ge};
      rem  <= rem_next;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = work;

endmodule

// File: rtl/core/bandwidth_on_demand_controller_core.sv
`timescale 1ns / 1ps
// Sequence: a channel transaction without tlast only updates the sums; a closing one that
//   only records the sample goes to S_OUT, a full rate update runs S_MUL1 and a 43-step
//   division in S_DIV1 per rate (filtering adds S_MUL2, S_DIV2), then S_DEC and S_OUT.
// Throughput: one channel transaction per cycle; a closing transaction holds tready low
//   until its result is loaded, so the shared bit-serial divider sets the sample rate.
// Reset: rst is synchronous, active high; clears history, sums, rates and loads defaults.
// ----------------------------------------------------------------------------
// bandwidth_on_demand_controller_core
// Sums per-channel byte counters, derives rx/tx rates once per sample (smoothed
// unless filter_len is 0 or 1) and commands adding or removing a second link.
// ----------------------------------------------------------------------------
module bandwidth_on_demand_controller_core #(
  parameter int MAX_CHANNELS = 16
) (
  input  logic          clk,
  input  logic          rst,
  // configuration write port
  input  logic          cfg_we,
  input  logic [2:0]    cfg_addr,
  input  logic [31:0]   cfg_data,
  // channel stream
  input  logic          s_tvalid,
  output logic          s_tready,
  // [0] channel_in_use, [32:1] channel_in_bytes, [64:33] channel_out_bytes,
  // [80:65] elapsed_ms, [112:81] now_seconds, [119:113] zero
  input  logic [119:0]  s_tdata,
  input  logic          s_tlast,   // last_channel
  // result stream
  output logic          m_tvalid,
  input  logic          m_tready,
  // [1:0] link_command, [33:2] rx_rate, [65:34] tx_rate,
  // [70:66] active_channels, [71] zero
  output logic [71:0]   m_tdata
);
  import bod_pkg::*;

  // active count saturates at the channel count, and at 31 for the 5-bit field
  localparam logic [4:0] CNT_CAP = (MAX_CHANNELS < 31) ? 5'(MAX_CHANNELS) : 5'd31;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;  // delta*1000, start first division
  localparam logic [2:0] S_DIV1 = 3'd2;  // wait for instantaneous rate
  localparam logic [2:0] S_MUL2 = 3'd3;  // old*(f-1)+inst, start second division
  localparam logic [2:0] S_DIV2 = 3'd4;  // wait for filtered rate
  localparam logic [2:0] S_DEC  = 3'd5;  // link decision
  localparam logic [2:0] S_OUT  = 3'd6;  // load result, commit history

  // configuration
  logic        enable;
  logic [7:0]  filter_len;
  logic [31:0] rate_limit;
  logic        stay_up;
  logic [15:0] stay_up_time;

  // state
  logic [2:0]  state;
  logic        sel;           // 0 = rx rate, 1 = tx rate
  logic [31:0] sum_in, sum_out;
  logic [4:0]  count_active;
  logic [31:0] prev_in, prev_out;
  logic [4:0]  prev_channels;
  logic        history_valid;
  logic [31:0] rate_rx, rate_tx;
  logic [31:0] link_up_time;

  // per-sample working registers
  logic [15:0]      ms;
  logic [31:0]      now;
  logic [4:0]       cnt;
  logic [1:0]       cmd;
  logic [DIV_W-1:0] inst;
  logic [71:0]      out_data;

  // input fields
  logic        f_in_use;
  logic [31:0] f_in_bytes, f_out_bytes, f_now;
  logic [15:0] f_ms;

  assign f_in_use    = s_tdata[0];
  assign f_in_bytes  = s_tdata[32:1];
  assign f_out_bytes = s_tdata[64:33];
  assign f_ms        = s_tdata[80:65];
  assign f_now       = s_tdata[112:81];

  logic        accept;
  logic [4:0]  cnt_inc;
  logic [31:0] sum_in_inc, sum_out_inc;
  logic        record_only;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign cnt_inc     = (f_in_use && count_active < CNT_CAP) ? count_active + 5'd1
                                                             : count_active;
  assign sum_in_inc  = f_in_use ? sum_in + f_in_bytes : sum_in;
  assign sum_out_inc = f_in_use ? sum_out + f_out_bytes : sum_out;
  assign record_only = !history_valid || (cnt_inc < prev_channels);

  // shared multiplier: 32 x 10, used for delta*1000 and old*(f-1)
  logic [31:0] mul_a;
  logic [9:0]  mul_b;
  logic [41:0] prod;
  logic [31:0] delta;
  logic [31:0] old_rate;
  logic [DIV_W-1:0] filt_sum;

  assign delta    = sel ? (sum_out - prev_out) : (sum_in - prev_in);
  assign old_rate = sel ? rate_tx : rate_rx;
  assign mul_a    = (state == S_MUL1) ? delta : old_rate;
  assign mul_b    = (state == S_MUL1) ? RATE_SCALE : {2'b00, filter_len - 8'd1};
  assign prod     = mul_a * mul_b;
  assign filt_sum = {1'b0, prod} + inst;

  div_req_t div_req;
  div_rsp_t div_rsp;

  always_comb begin
    div_req.start    = (state == S_MUL1) || (state == S_MUL2);
    div_req.dividend = (state == S_MUL1) ? {1'b0, prod} : filt_sum;
    div_req.divisor  = (state == S_MUL1) ? ms : {8'd0, filter_len};
  end

  bod_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  logic [31:0] q_sat;
  logic [31:0] up_for;
  logic        over_rx, over_tx;

  assign q_sat   = sat32(div_rsp.quotient);
  assign up_for  = now - link_up_time;
  assign over_rx = rate_rx > rate_limit;
  assign over_tx = rate_tx > rate_limit;

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= 1'b1;
      filter_len   <= 8'd5;
      rate_limit   <= 32'd7000;
      stay_up      <= 1'b0;
      stay_up_time <= 16'd30;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ENABLE:       enable       <= cfg_data[0];
        REG_FILTER_LEN:   filter_len   <= cfg_data[7:0];
        REG_RATE_LIMIT:   rate_limit   <= cfg_data;
        REG_STAY_UP:      stay_up      <= cfg_data[0];
        REG_STAY_UP_TIME: stay_up_time <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      sel           <= 1'b0;
      sum_in        <= '0;
      sum_out       <= '0;
      count_active  <= '0;
      prev_in       <= '0;
      prev_out      <= '0;
      prev_channels <= '0;
      history_valid <= 1'b0;
      rate_rx       <= '0;
      rate_tx       <= '0;
      link_up_time  <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      // S_OUT reloads the result register itself when the old one drains
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            count_active <= cnt_inc;
            sum_in       <= sum_in_inc;
            sum_out      <= sum_out_inc;
            if (s_tlast) begin
              ms  <= (f_ms == 16'd0) ? 16'd1 : f_ms;
              now <= f_now;
              cnt <= cnt_inc;
              cmd <= LINK_NONE;
              sel <= 1'b0;
              state <= record_only ? S_OUT : S_MUL1;
            end
          end
        end
        S_MUL1: state <= S_DIV1;
        S_DIV1: begin
          if (div_rsp.done) begin
            if (filter_len == 8'd0) begin
              if (sel) rate_tx <= q_sat;
              else     rate_rx <= q_sat;
              sel   <= 1'b1;
              state <= sel ? S_DEC : S_MUL1;
            end else begin
              inst  <= div_rsp.quotient;
              state <= S_MUL2;
            end
          end
        end
        S_MUL2: state <= S_DIV2;
        S_DIV2: begin
          if (div_rsp.done) begin
            if (sel) rate_tx <= q_sat;
            else     rate_rx <= q_sat;
            sel   <= 1'b1;
            state <= sel ? S_DEC : S_MUL1;
          end
        end
        S_DEC: begin
          // add and remove need opposite rate conditions, so they never collide
          if (cnt != 5'd0 && enable) begin
            if (cnt == 5'd1 && (over_rx || over_tx)) begin
              cmd          <= LINK_ADD;
              link_up_time <= now;
              cnt          <= 5'd2;
            end else if (cnt > 5'd1 && !over_rx && !over_tx && !stay_up &&
                         up_for > {16'd0, stay_up_time}) begin
              cmd <= LINK_REMOVE;
            end
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            out_data      <= {1'b0, cnt, rate_tx, rate_rx, cmd};
            m_tvalid      <= 1'b1;
            prev_in       <= sum_in;
            prev_out      <= sum_out;
            prev_channels <= cnt;
            history_valid <= 1'b1;
            sum_in        <= '0;
            sum_out       <= '0;
            count_active  <= '0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = out_data;

endmodule

// File: dv/tb_bandwidth_on_demand_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bandwidth_on_demand_controller_core
// Streams channel transactions into the controller and checks every closing
// decision against a cycle-free model of the sampling, rate and link logic.
// A short table covers reset, counter extremes, zero elapsed time and
// saturation. Random samples follow under several register settings, with
// random idle gaps on both streams.
// ----------------------------------------------------------------------------
module tb_bandwidth_on_demand_controller_core;
  import bod_pkg::*;

  localparam int MAX_CHANNELS   = 16;
  localparam int COUNT_CAP      = (MAX_CHANNELS < 31) ? MAX_CHANNELS : 31;
  localparam int MS_PER_SECOND  = 1000;
  localparam int PHASE_ITEMS    = 110;   // channel transactions per register setting
  localparam int NUM_PHASES     = 8;
  localparam int SETTLE_CYCLES  = 200;   // settle time after the expected decisions have drained
  localparam int WATCHDOG_LIMIT = 5000;  // cycles without any transaction
  localparam int REPORT_LIMIT   = 10;

  // one channel transaction as the model sees it
  typedef struct packed {
    logic        in_use;
    logic [31:0] in_b;
    logic [31:0] out_b;
    logic        last;
    logic [15:0] ms;
    logic [31:0] now;
  } channel_item_t;

  // one sample decision, fields in m_tdata order from the top down
  typedef struct packed {
    logic [4:0]  cnt;
    logic [31:0] tx;
    logic [31:0] rx;
    logic [1:0]  cmd;
  } link_decision_t;

  typedef struct {
    channel_item_t  it;
    bit             typed;   // expectation written out by hand
    link_decision_t res;
  } directed_row_t;

  typedef struct {
    bit          en;
    logic [7:0]  filt;
    logic [31:0] lim;
    bit          stay;
    logic [15:0] stay_t;
  } link_policy_t;

  // --------------------------------------------------------------------------
  // DUT signals, all driven ones known from time zero
  // --------------------------------------------------------------------------
  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_addr = REG_ENABLE;
  logic [31:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [119:0] s_tdata = '0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [71:0]  m_tdata;

  bandwidth_on_demand_controller_core #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Model state: register copies and controller state, reset values
  // --------------------------------------------------------------------------
  bit          cfg_enable    = 1'b1;
  logic [7:0]  cfg_filter    = 8'd5;
  logic [31:0] cfg_limit     = 32'd7000;
  bit          cfg_stay_up   = 1'b0;
  logic [15:0] cfg_stay_time = 16'd30;

  logic [31:0] acc_in = '0, acc_out = '0;     // sums of the open sample
  logic [4:0]  acc_count = '0;
  logic [31:0] last_in = '0, last_out = '0;   // sums of the previous sample
  logic [4:0]  last_count = '0;
  bit          have_history = 1'b0;
  logic [31:0] rx_est = '0, tx_est = '0;
  logic [31:0] link_since = '0;               // time the extra link was added

  link_decision_t pending_decisions[$];
  directed_row_t  dir_rows[$];

  int          error_count = 0;
  int          quiet_cycles = 0;
  int          tx_burst = 0;                  // sender stretch without gaps
  int          rx_burst = 0;                  // receiver stretch without stalls
  logic [31:0] run_in = '0, run_out = '0;     // running traffic totals for samples
  logic [31:0] wall_s = 32'd1000;             // wall clock in seconds

  // rate from a byte delta, smoothed over filter_len samples (none when 0), clipped to 32 bits
  function automatic logic [31:0] smooth_rate(input logic [31:0] old,
                                              input logic [31:0] delta,
                                              input logic [15:0] ms);
    logic [63:0] inst, acc;
    inst = (64'(delta) * 64'(MS_PER_SECOND)) / 64'(ms);
    if (cfg_filter == 8'd0) begin
      acc = inst;
    end else begin
      acc = (64'(old) * (64'(cfg_filter) - 64'd1) + inst) / 64'(cfg_filter);
    end
    return (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
  endfunction

  // consume one accepted channel transaction; a closing one yields a decision
  task automatic predict_link_decision(input channel_item_t it, output bit produced,
                                       output link_decision_t r);
    logic [15:0] ms;
    logic [4:0]  cnt;
    logic [1:0]  cmd;
    logic [31:0] since_add;
    produced = 1'b0;
    r = '0;
    if (it.in_use) begin
      if (acc_count < COUNT_CAP) acc_count++;
      acc_in  += it.in_b;
      acc_out += it.out_b;
    end
    if (it.last) begin
      ms  = (it.ms == 16'd0) ? 16'd1 : it.ms;   // zero elapsed counts as 1 ms
      cnt = acc_count;
      cmd = LINK_NONE;
      if (!have_history || cnt < last_count) begin
        have_history = 1'b1;                    // record only
      end else begin
        rx_est = smooth_rate(rx_est, acc_in - last_in, ms);
        tx_est = smooth_rate(tx_est, acc_out - last_out, ms);
        if (cnt != 5'd0 && cfg_enable) begin
          if (cnt == 5'd1 && (rx_est > cfg_limit || tx_est > cfg_limit)) begin
            cmd        = LINK_ADD;              // add always succeeds
            link_since = it.now;
            cnt        = 5'd2;
          end
          since_add = it.now - link_since;
          if (cnt > 5'd1 && rx_est <= cfg_limit && tx_est <= cfg_limit &&
              !cfg_stay_up && since_add > 32'(cfg_stay_time)) begin
            cmd = LINK_REMOVE;
          end
        end
      end
      last_count = cnt;
      last_in    = acc_in;
      last_out   = acc_out;
      r.cmd = cmd;
      r.rx  = rx_est;
      r.tx  = tx_est;
      r.cnt = cnt;
      produced = 1'b1;
      acc_in    = '0;
      acc_out   = '0;
      acc_count = '0;
    end
  endtask

  // idle draw shared by both streams: mostly a random idle gap, sometimes a gapless run
  function automatic int pick_wait(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      burst_left = $urandom_range(5, 40);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  // byte delta for one direction: half the time above the limit, half at or below
  function automatic logic [31:0] pick_delta(input logic [15:0] ms_eff);
    logic [63:0] lim, rate;
    lim = 64'(cfg_limit);
    if ($urandom_range(0, 1) == 1) begin
      rate = lim + 64'd1 + (lim * 64'($urandom_range(0, 100))) / 64'd100;
    end else begin
      rate = (lim * 64'($urandom_range(0, 100))) / 64'd100;
    end
    return 32'((rate * 64'(ms_eff)) / 64'(MS_PER_SECOND));
  endfunction

  // drive one channel transaction; the model sees it at the accepting edge
  task automatic send_item(input channel_item_t it, input bit typed,
                           input link_decision_t typed_res);
    int             gap;
    bit             produced;
    link_decision_t r;
    gap = pick_wait(tx_burst);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, it.now, it.ms, it.out_b, it.in_b, it.in_use};
    s_tlast  <= it.last;
    do @(posedge clk); while (s_tready !== 1'b1);
    predict_link_decision(it, produced, r);
    if (produced) pending_decisions.push_back(typed ? typed_res : r);
  endtask

  task automatic add_row(input bit use_ch, input logic [31:0] ib, input logic [31:0] ob,
                         input bit last, input logic [15:0] ms, input logic [31:0] now,
                         input bit typed, input logic [1:0] cmd, input logic [31:0] rx,
                         input logic [31:0] tx, input logic [4:0] cnt);
    directed_row_t row;
    row.it    = '{use_ch, ib, ob, last, ms, now};
    row.typed = typed;
    row.res   = '{cnt, tx, rx, cmd};
    dir_rows.push_back(row);
  endtask

  // One sample: a few active channels (mostly following the link state so
  // that rates are really updated), some idle channels, and a closing item.
  // Active byte counters are split so that their sum tracks a running total.
  task automatic send_sample(input bit noise, inout int sent);
    int             n_on, n_off, total, ra, ro;
    logic [15:0]    ms, ms_eff;
    logic [31:0]    want_in, want_out, part_in, part_out;
    channel_item_t  it;
    link_decision_t no_res;
    no_res = '0;
    if (noise) begin
      n_on = $urandom_range(0, 18);             // also pushes past the channel cap
    end else if (last_count >= 5'd2) begin
      n_on = ($urandom_range(0, 4) == 0) ? 1 : (($urandom_range(0, 5) == 0) ? 3 : 2);
    end else begin
      n_on = ($urandom_range(0, 3) == 0) ? 2 : 1;
    end
    n_off = $urandom_range(0, 2);
    if (n_on + n_off == 0) n_off = 1;
    total = n_on + n_off;
    case ($urandom_range(0, 19))
      0:       ms = 16'd0;
      1:       ms = 16'hFFFF;
      2, 3:    ms = 16'($urandom);
      default: ms = 16'($urandom_range(200, 3000));
    endcase
    ms_eff = (ms == 16'd0) ? 16'd1 : ms;
    if ($urandom_range(0, 29) == 0) begin
      wall_s = $urandom;                        // clock jump, exercises timer wrap
    end else begin
      wall_s += 32'($urandom_range(0, 12));
    end
    if (noise) begin
      want_in  = $urandom;
      want_out = $urandom;
    end else begin
      want_in  = run_in + pick_delta(ms_eff);
      want_out = run_out + pick_delta(ms_eff);
    end
    if (n_on != 0) begin
      run_in  = want_in;
      run_out = want_out;
    end
    part_in  = '0;
    part_out = '0;
    ra = n_on;
    ro = n_off;
    for (int i = 0; i < total; i++) begin
      it.in_use = (ro == 0) || (ra != 0 && $urandom_range(0, ra + ro - 1) < ra);
      it.last   = (i == total - 1);
      if (it.in_use && ra == 1) begin
        it.in_b  = want_in - part_in;
        it.out_b = want_out - part_out;
      end else begin
        it.in_b  = $urandom;
        it.out_b = $urandom;
      end
      if (it.in_use) begin
        part_in  += it.in_b;
        part_out += it.out_b;
        ra--;
      end else begin
        ro--;
      end
      // elapsed and time only count on the closing item; random elsewhere
      it.ms  = it.last ? ms : 16'($urandom);
      it.now = it.last ? wall_s : $urandom;
      send_item(it, 1'b0, no_res);
      sent++;
    end
  endtask

  // let every expected decision arrive, then let the block settle
  task automatic drain_block();
    s_tvalid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    link_policy_t pol;
    int           sent;
    logic [31:0]  junk;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed table under reset defaults (filter 5, limit 7000, stay-up 30 s).
    //       use  in_bytes      out_bytes     last ms        now          chk
    // first sample after reset: record only, rates still zero
    add_row(1, 32'h0000_0000, 32'h0000_0000, 1, 16'd1000, 32'd100,      1,
            LINK_NONE, 32'h0, 32'h0, 5'd1);
    // max delta with zero elapsed time: both rates saturate, link added
    add_row(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 16'd0,    32'd101,      1,
            LINK_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd2);
    // count fell from two to one: record only, rates held
    add_row(1, 32'h0000_0000, 32'h0000_0000, 1, 16'd1000, 32'd102,      1,
            LINK_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1);
    // no channel in use: count fell again, idle bytes ignored
    add_row(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 16'hFFFF, 32'hFFFF_FFFF, 1,
            LINK_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0);
    // counter wrap across two active channels, longest elapsed time
    add_row(1, 32'hFFFF_FFF0, 32'h0000_0001, 0, 16'hFFFF, 32'h5A5A_5A5A, 0,
            LINK_NONE, '0, '0, '0);
    add_row(0, 32'h1234_5678, 32'h9ABC_DEF0, 0, 16'h0000, 32'h0000_0000, 0,
            LINK_NONE, '0, '0, '0);
    add_row(1, 32'h0000_0020, 32'hFFFF_FFFF, 1, 16'hFFFF, 32'h0000_0000, 0,
            LINK_NONE, '0, '0, '0);
    // alternating bit patterns, one-ms elapsed
    add_row(1, 32'h0000_1000, 32'h0000_2000, 0, 16'h0000, 32'h0000_0000, 0,
            LINK_NONE, '0, '0, '0);
    add_row(0, 32'hAAAA_AAAA, 32'h5555_5555, 0, 16'hAAAA, 32'h5555_5555, 0,
            LINK_NONE, '0, '0, '0);
    add_row(1, 32'h5555_5555, 32'hAAAA_AAAA, 1, 16'd1,    32'd200,      0,
            LINK_NONE, '0, '0, '0);
    // single channel after two, then a full update from it
    add_row(1, 32'h8000_0000, 32'h8000_0000, 1, 16'h8000, 32'h8000_0000, 0,
            LINK_NONE, '0, '0, '0);
    add_row(1, 32'h0000_0000, 32'h0000_0000, 1, 16'd1000, 32'h8000_0010, 0,
            LINK_NONE, '0, '0, '0);
    add_row(1, 32'h0001_0000, 32'h0000_0100, 1, 16'd500,  32'h8000_0020, 0,
            LINK_NONE, '0, '0, '0);

    for (int i = 0; i < dir_rows.size(); i++) begin
      send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);
    end

    // Random samples, one register setting per phase.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain_block();
      case (phase)
        0:       pol = '{1'b1, 8'd0,   32'd7000,       1'b0, 16'd30};
        1:       pol = '{1'b1, 8'd1,   32'd0,          1'b0, 16'd0};
        2:       pol = '{1'b1, 8'd255, 32'hFFFF_FFFF,  1'b0, 16'hFFFF};
        3:       pol = '{1'b0, 8'd3,   32'd5000,       1'b0, 16'd10};
        4:       pol = '{1'b1, 8'd2,   32'd20000,      1'b1, 16'd10};
        5:       pol = '{1'b1, 8'd0,   32'd100000,     1'b0, 16'd5};
        6: begin
          pol.en     = 1'b1;
          pol.filt   = 8'($urandom_range(0, 8));
          pol.lim    = $urandom_range(1000, 1000000);
          pol.stay   = ($urandom_range(0, 3) == 0);
          pol.stay_t = 16'($urandom_range(0, 40));
        end
        default: begin
          pol.en     = ($urandom_range(0, 3) != 0);
          pol.filt   = 8'($urandom);
          pol.lim    = $urandom;
          pol.stay   = 1'($urandom_range(0, 1));
          pol.stay_t = 16'($urandom);
        end
      endcase
      // all five registers, junk in the unused upper bits, then a write to an
      // unused index that must be ignored
      for (int w = 0; w < 6; w++) begin
        junk = $urandom;
        cfg_we <= 1'b1;
        case (w)
          0: begin
            cfg_addr <= REG_ENABLE;
            cfg_data <= {junk[31:1], pol.en};
          end
          1: begin
            cfg_addr <= REG_FILTER_LEN;
            cfg_data <= {junk[31:8], pol.filt};
          end
          2: begin
            cfg_addr <= REG_RATE_LIMIT;
            cfg_data <= pol.lim;
          end
          3: begin
            cfg_addr <= REG_STAY_UP;
            cfg_data <= {junk[31:1], pol.stay};
          end
          4: begin
            cfg_addr <= REG_STAY_UP_TIME;
            cfg_data <= {junk[31:16], pol.stay_t};
          end
          default: begin
            cfg_addr <= REG_STAY_UP_TIME + 3'($urandom_range(1, 3));
            cfg_data <= junk;
          end
        endcase
        @(posedge clk);
      end
      cfg_we <= 1'b0;
      cfg_enable    = pol.en;
      cfg_filter    = pol.filt;
      cfg_limit     = pol.lim;
      cfg_stay_up   = pol.stay;
      cfg_stay_time = pol.stay_t;
      @(posedge clk);

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        send_sample($urandom_range(0, 6) == 0, sent);
      end
    end

    drain_block();
    if (error_count == 0 && pending_decisions.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random stalls, some of them while a result is already valid
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int             stall;
    link_decision_t got, want;
    wait (rst == 1'b0);
    forever begin
      stall = pick_wait(rx_burst);
      if (stall != 0) begin
        m_tready <= 1'b0;
        do @(posedge clk); while (m_tvalid !== 1'b1);
        repeat (stall - 1) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      // transaction at this edge
      got.cmd = m_tdata[1:0];
      got.rx  = m_tdata[33:2];
      got.tx  = m_tdata[65:34];
      got.cnt = m_tdata[70:66];
      if (pending_decisions.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("[%0t] result with none expected: cmd %0d rx %0d tx %0d cnt %0d",
                   $realtime, got.cmd, got.rx, got.tx, got.cnt);
        end
      end else begin
        want = pending_decisions.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("[%0t] mismatch exp/act: cmd %0d/%0d rx %0d/%0d tx %0d/%0d cnt %0d/%0d",
                     $realtime, want.cmd, got.cmd, want.rx, got.rx, want.tx, got.tx,
                     want.cnt, got.cnt);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any transaction on either stream or config
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
